@@ src/cfq_pkg.sv @@
// ----------------------------------------------------------------------------
// cfq_pkg
// Shared types and codes for the circular FIFO queue core.
// ----------------------------------------------------------------------------
package cfq_pkg;

  localparam int unsigned IdW = 32;

  // request codes as they arrive on req_type; the fourth code is unused
  typedef enum logic [1:0] {
    OP_ENQ  = 2'd0,
    OP_DEQ  = 2'd1,
    OP_SHOW = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    ST_ADDED      = 3'd0,
    ST_FULL       = 3'd1,
    ST_DEQUEUED   = 3'd2,
    ST_EMPTY      = 3'd3,
    ST_SHOW       = 3'd4,
    ST_SHOW_EMPTY = 3'd5
  } status_e;

  typedef enum logic {
    BK_IDLE = 1'b0,
    BK_READ = 1'b1
  } back_state_e;

  // classified request handed from front to back
  typedef struct packed {
    op_e              kind;
    logic [IdW-1:0]   id;
  } op_t;

  typedef struct packed {
    status_e          status;
    logic [IdW-1:0]   id;
    logic             last;
  } res_t;

endpackage

@@ src/cfq_front.sv @@
// ----------------------------------------------------------------------------
// cfq_front
// Takes requests, drops the unused code and buffers the rest in a
// two-entry queue for the back end.
// ----------------------------------------------------------------------------
module cfq_front
  import cfq_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [1:0]      req_type_i,
  input  logic [IdW-1:0]  customer_id_i,
  output logic            op_valid_o,
  output op_t             op_o,
  input  logic            op_pop_i
);

  logic [1:0] cnt_q, cnt_d;
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  op_t        slot_q [2];
  logic       known;
  logic       push;
  logic       pop;

  always_comb begin
    unique case (req_type_i)
      OP_ENQ, OP_DEQ, OP_SHOW: known = 1'b1;
      default:                 known = 1'b0;
    endcase
  end

  assign in_stall_o = (cnt_q == 2'd2);
  // unused request code is accepted and dropped here
  assign push       = in_valid_i && !in_stall_o && known;
  assign pop        = op_pop_i && (cnt_q != 2'd0);

  always_comb begin
    cnt_d    = cnt_q;
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push) begin
      wr_ptr_d = ~wr_ptr_q;
    end
    if (pop) begin
      rd_ptr_d = ~rd_ptr_q;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= 2'd0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
    end else begin
      cnt_q    <= cnt_d;
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= '{kind: op_e'(req_type_i), id: customer_id_i};
    end
  end

  assign op_valid_o = (cnt_q != 2'd0);
  assign op_o       = slot_q[rd_ptr_q];

endmodule

@@ src/cfq_back.sv @@
// ----------------------------------------------------------------------------
// cfq_back
// Executes requests against the slot memory and drives the result register.
// ----------------------------------------------------------------------------
module cfq_back
  import cfq_pkg::*;
#(
  parameter int unsigned DEPTH = 8
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  op_valid_i,
  input  op_t   op_i,
  output logic  op_pop_o,
  output logic  out_valid_o,
  input  logic  out_stall_i,
  output res_t  res_o
);

  localparam int unsigned IdxW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(DEPTH - 1);
  localparam logic [CntW-1:0] Full    = CntW'(DEPTH);

  back_state_e     state_q, state_d;
  logic [IdxW-1:0] head_q, head_d;
  logic [IdxW-1:0] tail_q, tail_d;
  logic [IdxW-1:0] walk_q, walk_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CntW-1:0] left_q, left_d;
  op_e             kind_q, kind_d;
  res_t            res_q, res_d;
  logic            out_vld_q, out_vld_d;

  logic [IdW-1:0]  mem_q [DEPTH];
  logic [IdW-1:0]  rd_q;
  logic            mem_we;
  logic            rd_en;
  logic [IdxW-1:0] rd_addr;

  logic            out_free;
  logic            empty;
  logic            full;
  logic            load;

  function automatic logic [IdxW-1:0] adv(input logic [IdxW-1:0] idx);
    adv = (idx == LastIdx) ? '0 : idx + IdxW'(1);
  endfunction

  assign out_free = !out_vld_q || !out_stall_i;
  assign empty    = (cnt_q == '0);
  assign full     = (cnt_q == Full);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: begin
        if (op_valid_i && out_free && !empty &&
            (op_i.kind == OP_DEQ || op_i.kind == OP_SHOW)) begin
          state_d = BK_READ;
        end
      end
      BK_READ: begin
        if (out_free && (kind_q == OP_DEQ || left_q == CntW'(1))) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  // datapath and handshake outputs
  always_comb begin
    head_d   = head_q;
    tail_d   = tail_q;
    walk_d   = walk_q;
    cnt_d    = cnt_q;
    left_d   = left_q;
    kind_d   = kind_q;
    res_d    = res_q;
    load     = 1'b0;
    op_pop_o = 1'b0;
    mem_we   = 1'b0;
    rd_en    = 1'b0;
    rd_addr  = head_q;
    unique case (state_q)
      BK_IDLE: begin
        if (op_valid_i && out_free) begin
          op_pop_o = 1'b1;
          unique case (op_i.kind)
            OP_ENQ: begin
              load = 1'b1;
              if (full) begin
                res_d = '{status: ST_FULL, id: '0, last: 1'b1};
              end else begin
                mem_we = 1'b1;
                tail_d = adv(tail_q);
                cnt_d  = cnt_q + CntW'(1);
                res_d  = '{status: ST_ADDED, id: op_i.id, last: 1'b1};
              end
            end
            OP_DEQ: begin
              if (empty) begin
                load  = 1'b1;
                res_d = '{status: ST_EMPTY, id: '0, last: 1'b1};
              end else begin
                rd_en  = 1'b1;
                kind_d = OP_DEQ;
              end
            end
            OP_SHOW: begin
              if (empty) begin
                load  = 1'b1;
                res_d = '{status: ST_SHOW_EMPTY, id: '0, last: 1'b1};
              end else begin
                rd_en  = 1'b1;
                kind_d = OP_SHOW;
                walk_d = head_q;
                left_d = cnt_q;
              end
            end
            default: begin
              load = 1'b0;
            end
          endcase
        end
      end
      BK_READ: begin
        if (out_free) begin
          load = 1'b1;
          if (kind_q == OP_DEQ) begin
            res_d  = '{status: ST_DEQUEUED, id: rd_q, last: 1'b1};
            head_d = adv(head_q);
            cnt_d  = cnt_q - CntW'(1);
          end else begin
            res_d = '{status: ST_SHOW, id: rd_q, last: (left_q == CntW'(1))};
            if (left_q != CntW'(1)) begin
              // fetch the next entry of the walk while this one goes out
              rd_en   = 1'b1;
              rd_addr = adv(walk_q);
              walk_d  = adv(walk_q);
              left_d  = left_q - CntW'(1);
            end
          end
        end
      end
      default: begin
        load = 1'b0;
      end
    endcase
    out_vld_d = load ? 1'b1 : (out_free ? 1'b0 : out_vld_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= BK_IDLE;
      head_q    <= '0;
      tail_q    <= '0;
      walk_q    <= '0;
      cnt_q     <= '0;
      left_q    <= '0;
      kind_q    <= OP_DEQ;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      head_q    <= head_d;
      tail_q    <= tail_d;
      walk_q    <= walk_d;
      cnt_q     <= cnt_d;
      left_q    <= left_d;
      kind_q    <= kind_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[tail_q] <= op_i.id;
    end
    if (rd_en) begin
      rd_q <= mem_q[rd_addr];
    end
  end

  assign out_valid_o = out_vld_q;
  assign res_o       = res_q;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= Full)
    else $error("entry count above depth");

  a_no_write_in_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_READ) |-> !mem_we)
    else $error("store written during a read sequence");

  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_READ && kind_q == OP_SHOW) |-> (left_q != '0 && left_q <= cnt_q))
    else $error("display walk out of range");

  a_ptr_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0 || cnt_q == Full) |-> (head_q == tail_q))
    else $error("head and tail disagree with count");
`endif

endmodule

@@ src/circular_fifo_queue_core.sv @@
// ----------------------------------------------------------------------------
// circular_fifo_queue_core
// Bounded circular FIFO of 32-bit identifiers with enqueue, dequeue and
// display requests.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+----------------------------
//   in      | input     | in_valid_i / in_stall_o  | req_type_i, customer_id_i
//   out     | output    | out_valid_o / out_stall_i| status_o, item_id_o, last_o
//
// enqueue and every refusal load the result register directly; dequeue first
// reads the slot memory, which has a registered read port; display of n entries
// gives n words, one word per cycle through that same read port while out is not stalled.
// reset clears head, tail, count and all valid flags; slot contents are kept.
// a two-entry request queue keeps taking requests while the result register
// is stalled, until both entries fill; the result register holds its word until taken.
// ----------------------------------------------------------------------------
module circular_fifo_queue_core
  import cfq_pkg::*;
#(
  parameter int unsigned DEPTH = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         req_type_i,
  input  logic signed [31:0] customer_id_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [2:0]         status_o,
  output logic signed [31:0] item_id_o,
  output logic               last_o
);

  logic op_valid;
  op_t  op;
  logic op_pop;
  res_t res;

  cfq_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .req_type_i    (req_type_i),
    .customer_id_i ($unsigned(customer_id_i)),
    .op_valid_o    (op_valid),
    .op_o          (op),
    .op_pop_i      (op_pop)
  );

  cfq_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_valid_i  (op_valid),
    .op_i        (op),
    .op_pop_o    (op_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res)
  );

  assign status_o  = res.status;
  assign item_id_o = $signed(res.id);
  assign last_o    = res.last;

endmodule

@@ dv/circular_fifo_queue_checker.sv @@
// ----------------------------------------------------------------------------
// circular_fifo_queue_checker
// Watches both channels of the circular FIFO queue core. Every accepted
// request is run through a behavioral model of the queue, which lines up
// the words the core owes. Every accepted output word is compared field by
// field against the oldest owed word. Hands back a mismatch count and the
// number of words still owed.
// ----------------------------------------------------------------------------
module circular_fifo_queue_checker
  import cfq_pkg::*;
#(
  parameter int unsigned DEPTH = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic [1:0]         req_type_i,
  input  logic signed [31:0] customer_id_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic [2:0]         status_i,
  input  logic signed [31:0] item_id_i,
  input  logic               last_i,
  output int                 fail_cnt_o,
  output int                 pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [IdW-1:0] slot_mem [DEPTH];
  int unsigned    head_ptr;
  int unsigned    tail_ptr;
  int unsigned    held_cnt;
  res_t           owed_q [$];
  int             errs = 0;

  function automatic int unsigned wrap_inc(int unsigned idx);
    return (idx + 1 >= DEPTH) ? 0 : idx + 1;
  endfunction

  function automatic res_t make_word(status_e st, logic [IdW-1:0] id, logic lst);
    res_t w;
    w.status = st;
    w.id     = id;
    w.last   = lst;
    return w;
  endfunction

  task automatic report_mismatch(string msg);
    errs++;
    if (errs <= 40) $display("%0t ns mismatch: %s", $time, msg);
  endtask

  // queue behavior: what one accepted request owes and how it moves the state
  task automatic forecast_replies(logic [1:0] kind, logic [IdW-1:0] id);
    int unsigned idx;
    case (kind)
      OP_ENQ: begin
        if (held_cnt >= DEPTH) begin
          owed_q.push_back(make_word(ST_FULL, '0, 1'b1));
        end else begin
          slot_mem[tail_ptr] = id;
          tail_ptr = wrap_inc(tail_ptr);
          held_cnt++;
          owed_q.push_back(make_word(ST_ADDED, id, 1'b1));
        end
      end
      OP_DEQ: begin
        if (held_cnt == 0) begin
          owed_q.push_back(make_word(ST_EMPTY, '0, 1'b1));
        end else begin
          owed_q.push_back(make_word(ST_DEQUEUED, slot_mem[head_ptr], 1'b1));
          head_ptr = wrap_inc(head_ptr);
          held_cnt--;
        end
      end
      OP_SHOW: begin
        if (held_cnt == 0) begin
          owed_q.push_back(make_word(ST_SHOW_EMPTY, '0, 1'b1));
        end else begin
          idx = head_ptr;
          for (int unsigned i = 0; i < held_cnt; i++) begin
            owed_q.push_back(make_word(ST_SHOW, slot_mem[idx], i + 1 == held_cnt));
            idx = wrap_inc(idx);
          end
        end
      end
      default: ; // spare code is dropped by the core
    endcase
  endtask

  task automatic check_word();
    res_t want;
    if (owed_q.size() == 0) begin
      report_mismatch($sformatf("word with nothing owed: status %0d id %h last %0b",
                                status_i, item_id_i, last_i));
    end else begin
      want = owed_q.pop_front();
      if (status_i !== want.status)
        report_mismatch($sformatf("status %0d, want %0d", status_i, want.status));
      if (item_id_i !== want.id)
        report_mismatch($sformatf("item_id %h, want %h", item_id_i, want.id));
      if (last_i !== want.last)
        report_mismatch($sformatf("last %0b, want %0b", last_i, want.last));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_ptr = 0;
      tail_ptr = 0;
      held_cnt = 0;
      owed_q.delete();
      pending_o  <= 0;
      fail_cnt_o <= errs;
    end else begin
      // output first: a word leaving now can only belong to an older request
      if (out_valid_i && !out_stall_i) check_word();
      if (in_valid_i && !in_stall_i) forecast_replies(req_type_i, customer_id_i);
      pending_o  <= owed_q.size();
      fail_cnt_o <= errs;
    end
  end

endmodule

@@ dv/circular_fifo_queue_core_tb.sv @@
// ----------------------------------------------------------------------------
// circular_fifo_queue_core_tb
// Drives enqueue, dequeue, display and spare requests into the queue core:
// a directed pass over empty, full, wrap-around and extreme identifiers,
// then random fill and drain runs under several idle and stall mixes.
// Checking is done by the checker instance beside the core.
// ----------------------------------------------------------------------------
module circular_fifo_queue_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cfq_pkg::*;

  localparam int unsigned DEPTH       = 8;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned PHASE_WORDS = 24;
  localparam int unsigned TAIL_CYCLES = 2 * DEPTH + 8;
  localparam logic [1:0]  OP_SPARE    = 2'd3;

  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               in_valid_i    = 1'b0;
  logic               in_stall_o;
  logic [1:0]         req_type_i    = OP_ENQ;
  logic signed [31:0] customer_id_i = '0;
  logic               out_valid_o;
  logic               out_stall_i   = 1'b0;
  logic [2:0]         status_o;
  logic signed [31:0] item_id_o;
  logic               last_o;

  int          fail_cnt;
  int          pending;
  int unsigned idle_pct  = 0;
  int unsigned stall_pct = 0;
  int unsigned cycles    = 0;

  circular_fifo_queue_core #(
    .DEPTH(DEPTH)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .req_type_i   (req_type_i),
    .customer_id_i(customer_id_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_o     (status_o),
    .item_id_o    (item_id_o),
    .last_o       (last_o)
  );

  circular_fifo_queue_checker #(
    .DEPTH(DEPTH)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .req_type_i   (req_type_i),
    .customer_id_i(customer_id_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_i     (status_o),
    .item_id_i    (item_id_o),
    .last_i       (last_o),
    .fail_cnt_o   (fail_cnt),
    .pending_o    (pending)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // hold one request word until the core takes it
  task automatic issue(logic [1:0] kind, logic [31:0] id);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    req_type_i    <= kind;
    customer_id_i <= id;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_id();
    case ($urandom_range(9))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [1:0] pick_op(bit filling);
    int unsigned r;
    r = $urandom_range(99);
    if (r < 3)  return OP_SPARE;
    if (r < 20) return OP_SHOW;
    if (filling) return (r < 85) ? OP_ENQ : OP_DEQ;
    return (r < 85) ? OP_DEQ : OP_ENQ;
  endfunction

  initial begin
    int unsigned sent;
    logic [1:0]  kind;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty queue corner cases and the spare code
    issue(OP_SHOW, 32'h0000_0000);
    issue(OP_DEQ, 32'h1234_5678);
    issue(OP_SPARE, 32'hFFFF_FFFF);
    // fill to the brim with extreme identifiers, then one refused word
    issue(OP_ENQ, 32'h7FFF_FFFF);
    issue(OP_ENQ, 32'h8000_0000);
    issue(OP_ENQ, 32'h0000_0000);
    issue(OP_ENQ, 32'hFFFF_FFFF);
    issue(OP_ENQ, 32'h0000_0001);
    issue(OP_ENQ, 32'hAAAA_AAAA);
    issue(OP_ENQ, 32'h5555_5555);
    issue(OP_ENQ, $urandom);
    issue(OP_ENQ, 32'h0BAD_F00D);
    issue(OP_SHOW, 32'h0000_0000);
    // partial drain and refill so the stored entries wrap around the slot memory
    repeat (3) issue(OP_DEQ, $urandom);
    issue(OP_ENQ, 32'hDEAD_BEEF);
    issue(OP_ENQ, $urandom);
    issue(OP_SHOW, $urandom);
    repeat (2) issue(OP_DEQ, 32'h0000_0000);
    issue(OP_SHOW, 32'h0000_0000);
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 45; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 45; end
        default: begin idle_pct = 9;  stall_pct = 9;  end
      endcase
      sent = 0;
      while (sent < PHASE_WORDS) begin
        // push toward full for a stretch, then toward empty
        kind = pick_op(sent < 16);
        issue(kind, pick_id());
        if (kind != OP_SPARE) sent++;
      end
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_cnt == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
